// ===== hw/rtl/gbasd_pkg.sv =====
// Shared types, constants and the axis conditioning function for the
// gamepad button age and stick deadzone block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbasd_pkg;

  // register file geometry
  localparam int CFG_W       = 7;
  localparam int CFG_INDEX_W = 1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEADZONE   = 1'b0,
    REG_AXIS_LIMIT = 1'b1
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] DEADZONE_RESET   = 7'd10;
  localparam logic [CFG_W-1:0] AXIS_LIMIT_RESET = 7'd64;

  // counter constants
  localparam logic [7:0] AGE_RESET = 8'd250;
  localparam logic [7:0] COUNT_MAX = 8'd255;

  // square root unit: 15-bit radicand, one result bit per step
  localparam int RAD_W      = 15;
  localparam int ROOT_STEPS = 8;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture the input word
    logic cond;        // register conditioned axes
    logic scan_start;  // start the per-button counter scan
    logic square;      // register axis squares
    logic root_start;  // launch both square roots
    logic out_load;    // move results to the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_busy;
    logic root_busy;
    logic out_free;
  } dp_status_t;

  // Deadzone removal and clamp. v is the raw (possibly negated) axis,
  // range -128..128.
  function automatic logic signed [7:0] condition_axis(
    input logic signed [8:0] v,
    input logic [CFG_W-1:0]  dz,
    input logic [CFG_W-1:0]  rg
  );
    logic signed [9:0] w;
    logic signed [9:0] d;
    logic signed [9:0] r;
    logic signed [9:0] t;
    logic [8:0]        a;
    w = {v[8], v};
    d = {3'b000, dz};
    r = {3'b000, rg};
    a = v[8] ? 9'(-v) : v;
    if (a < {2'b00, dz}) begin
      t = '0;
    end else if (w > 10'sd0) begin
      t = w - d;
      if (t > r) t = r;
    end else begin
      t = w + d;
      if (t < -r) t = -r;
    end
    return t[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/gbasd_isqrt.sv =====
// Iterative integer square root, two radicand bits per cycle.
// Depends on gbasd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbasd_isqrt import gbasd_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [RAD_W-1:0] n,
  output logic                  busy,
  output logic [7:0]            root
);

  localparam int CNT_W = $clog2(ROOT_STEPS);

  logic [15:0]      rem;
  logic [15:0]      res;
  logic [15:0]      bit_r;
  logic [CNT_W-1:0] cnt;
  logic [15:0]      trial;

  assign trial = res + bit_r;

  // control: step count and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(ROOT_STEPS - 1)) busy <= 1'b0;
    end
  end

  // one digit-pair step of the restoring root
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= 16'(n);
      res   <= '0;
      bit_r <= 16'h4000;
    end else if (busy) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        res <= (res >> 1) + bit_r;
      end else begin
        res <= res >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign root = res[7:0];

endmodule

`default_nettype wire

// ===== hw/rtl/gbasd_ctrl.sv =====
// Controller state machine: input handshake and sequencing of the datapath.
// Depends on gbasd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbasd_ctrl import gbasd_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_COND   = 5'b00010,
    ST_SQUARE = 5'b00100,
    ST_ROOT   = 5'b01000,
    ST_WAIT   = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_COND;
        end
      end
      ST_COND: begin
        cmd.cond       = 1'b1;
        cmd.scan_start = 1'b1;
        state_next     = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_next = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_start = 1'b1;
        state_next     = ST_WAIT;
      end
      ST_WAIT: begin
        if (!status.scan_busy && !status.root_busy && status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gbasd_datapath.sv =====
// Datapath: config registers, axis conditioning, squares, two root units,
// counter memory scan and the output register. Depends on gbasd_pkg and
// gbasd_isqrt.
`timescale 1ns / 1ps
`default_nettype none

module gbasd_datapath import gbasd_pkg::*; #(
  parameter int BUTTONS = 16,
  parameter int SLOTS   = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // config
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]       wr_data,
  // input word
  input  wire logic [1:0]             slot,
  input  wire logic [15:0]            pressed_mask,
  input  wire logic [15:0]            held_mask,
  input  wire logic signed [7:0]      main_x,
  input  wire logic signed [7:0]      main_y,
  input  wire logic signed [7:0]      aux_x,
  input  wire logic signed [7:0]      aux_y,
  input  wire logic [3:0]             query_button,
  // control
  input  wire ctrl_cmd_t              cmd,
  output dp_status_t                  status,
  // output word
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [7:0]           main_x_out,
  output logic signed [7:0]           main_y_out,
  output logic signed [7:0]           aux_x_out,
  output logic signed [7:0]           aux_y_out,
  output logic [7:0]                  main_magnitude,
  output logic [7:0]                  aux_magnitude,
  output logic [7:0]                  press_age,
  output logic [7:0]                  held_frames
);

  localparam int DEPTH = SLOTS * BUTTONS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;

  // config registers
  logic [CFG_W-1:0] deadzone;
  logic [CFG_W-1:0] axis_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone   <= DEADZONE_RESET;
      axis_limit <= AXIS_LIMIT_RESET;
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_DEADZONE:   deadzone   <= wr_data;
        REG_AXIS_LIMIT: axis_limit <= wr_data;
        default: ;
      endcase
    end
  end

  // captured input word
  logic [1:0]        slot_r;
  logic [15:0]       pmask_r;
  logic [15:0]       hmask_r;
  logic signed [7:0] mx_r, my_r, ax_r, ay_r;
  logic [3:0]        query_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      slot_r  <= slot;
      pmask_r <= pressed_mask;
      hmask_r <= held_mask;
      mx_r    <= main_x;
      my_r    <= main_y;
      ax_r    <= aux_x;
      ay_r    <= aux_y;
      query_r <= query_button;
    end
  end

  // axis conditioning, Y negated so up is positive
  logic signed [8:0] mx9, my9, ax9, ay9;
  logic signed [7:0] mx_c, my_c, ax_c, ay_c;

  always_comb begin
    mx9 = 9'(mx_r);
    my9 = -(9'(my_r));
    ax9 = 9'(ax_r);
    ay9 = -(9'(ay_r));
  end

  always_ff @(posedge clk) begin
    if (cmd.cond) begin
      mx_c <= condition_axis(mx9, deadzone, axis_limit);
      my_c <= condition_axis(my9, deadzone, axis_limit);
      ax_c <= condition_axis(ax9, deadzone, axis_limit);
      ay_c <= condition_axis(ay9, deadzone, axis_limit);
    end
  end

  // squares of the conditioned axes
  logic signed [15:0] mxx, myy, axx, ayy;
  logic [13:0]        mxx_r, myy_r, axx_r, ayy_r;

  always_comb begin
    mxx = mx_c * mx_c;
    myy = my_c * my_c;
    axx = ax_c * ax_c;
    ayy = ay_c * ay_c;
  end

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      mxx_r <= mxx[13:0];
      myy_r <= myy[13:0];
      axx_r <= axx[13:0];
      ayy_r <= ayy[13:0];
    end
  end

  // stick magnitudes
  logic       main_busy, aux_busy;
  logic [7:0] main_root, aux_root;

  gbasd_isqrt u_main_root (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .n     (RAD_W'(mxx_r) + RAD_W'(myy_r)),
    .busy  (main_busy),
    .root  (main_root)
  );

  gbasd_isqrt u_aux_root (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.root_start),
    .n     (RAD_W'(axx_r) + RAD_W'(ayy_r)),
    .busy  (aux_busy),
    .root  (aux_root)
  );

  // counter scan: read stage then update/write stage, one button a cycle
  logic          slot_ok;
  logic          rd_active;
  logic [IW-1:0] rd_idx;
  logic [AW-1:0] rd_addr;
  logic          wr_active;
  logic [IW-1:0] wr_idx;
  logic [AW-1:0] wr_addr;

  assign slot_ok = (32'(slot_r) < SLOTS);
  assign rd_addr = AW'(32'(slot_r) * BUTTONS + 32'(rd_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active <= 1'b0;
      wr_active <= 1'b0;
      rd_idx    <= '0;
    end else begin
      wr_active <= rd_active;
      if (cmd.scan_start) begin
        rd_active <= slot_ok;
        rd_idx    <= '0;
      end else if (rd_active) begin
        if (rd_idx == IW'(BUTTONS - 1)) rd_active <= 1'b0;
        else                            rd_idx    <= rd_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_active) begin
      wr_idx  <= rd_idx;
      wr_addr <= rd_addr;
    end
  end

  // counter memory with per-entry valid bits for the reset values
  logic [15:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [15:0] rd_data;
  logic        rd_ok;
  logic [7:0]  age_cur, held_cur;
  logic [7:0]  age_new, held_new;
  logic [31:0] pm_ext, hm_ext;
  logic        p_bit, h_bit;

  always_ff @(posedge clk) begin
    if (wr_active) mem[wr_addr] <= {age_new, held_new};
    if (rd_active) begin
      rd_data <= mem[rd_addr];
      rd_ok   <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst)            valid          <= '0;
    else if (wr_active) valid[wr_addr] <= 1'b1;
  end

  // saturating counter update; buttons 16 to 31 see no mask bits, index 32 and up wraps
  always_comb begin
    pm_ext   = 32'(pmask_r);
    hm_ext   = 32'(hmask_r);
    p_bit    = pm_ext[5'(wr_idx)];
    h_bit    = hm_ext[5'(wr_idx)];
    age_cur  = rd_ok ? rd_data[15:8] : AGE_RESET;
    held_cur = rd_ok ? rd_data[7:0]  : 8'd0;
    if (p_bit)                    age_new = 8'd0;
    else if (age_cur < COUNT_MAX) age_new = age_cur + 8'd1;
    else                          age_new = age_cur;
    if (!h_bit)                    held_new = 8'd0;
    else if (held_cur < COUNT_MAX) held_new = held_cur + 8'd1;
    else                           held_new = held_cur;
  end

  // queried button capture, zero if never matched
  logic [7:0] q_age, q_held;

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      q_age  <= '0;
      q_held <= '0;
    end else if (wr_active && (6'(query_r) == 6'(wr_idx))) begin
      q_age  <= age_new;
      q_held <= held_new;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst)               out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (!out_stall)   out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      main_x_out     <= mx_c;
      main_y_out     <= my_c;
      aux_x_out      <= ax_c;
      aux_y_out      <= ay_c;
      main_magnitude <= main_root;
      aux_magnitude  <= aux_root;
      press_age      <= q_age;
      held_frames    <= q_held;
    end
  end

  // status back to the controller
  always_comb begin
    status.scan_busy = rd_active || wr_active;
    status.root_busy = main_busy || aux_busy;
    status.out_free  = !out_valid || !out_stall;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gamepad_button_age_and_stick_deadzone.sv =====
// Top level of the gamepad button age and stick deadzone block.
// Depends on gbasd_pkg, gbasd_ctrl, gbasd_datapath (and gbasd_isqrt).
//
//   channel  direction  handshake               payload
//   input    in         in_valid / in_stall     slot, masks, four axes, query_button
//   output   out        out_valid / out_stall   four axes, two magnitudes, age, held
//   config   in         wr_en                   wr_index, wr_data
//
// Between one accept and the next, the counter memory scan visits one button
// per cycle and the two root units need 8 steps. Reset is synchronous; it
// sets the config registers to their defaults, clears the controller state
// and out_valid, and marks every counter entry as at its reset value at once.
// A result waits in the output register while out_stall is high; the next
// frame is still accepted and processed, and only its final transfer waits.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_button_age_and_stick_deadzone import gbasd_pkg::*; #(
  parameter int BUTTONS = 16,
  parameter int SLOTS   = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // config
  input  wire logic                   wr_en,
  input  wire logic [CFG_INDEX_W-1:0] wr_index,
  input  wire logic [CFG_W-1:0]       wr_data,
  // input channel
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             slot,
  input  wire logic [15:0]            pressed_mask,
  input  wire logic [15:0]            held_mask,
  input  wire logic signed [7:0]      main_x,
  input  wire logic signed [7:0]      main_y,
  input  wire logic signed [7:0]      aux_x,
  input  wire logic signed [7:0]      aux_y,
  input  wire logic [3:0]             query_button,
  // output channel
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic signed [7:0]           main_x_out,
  output logic signed [7:0]           main_y_out,
  output logic signed [7:0]           aux_x_out,
  output logic signed [7:0]           aux_y_out,
  output logic [7:0]                  main_magnitude,
  output logic [7:0]                  aux_magnitude,
  output logic [7:0]                  press_age,
  output logic [7:0]                  held_frames
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  gbasd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  gbasd_datapath #(
    .BUTTONS (BUTTONS),
    .SLOTS   (SLOTS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .slot           (slot),
    .pressed_mask   (pressed_mask),
    .held_mask      (held_mask),
    .main_x         (main_x),
    .main_y         (main_y),
    .aux_x          (aux_x),
    .aux_y          (aux_y),
    .query_button   (query_button),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .main_x_out     (main_x_out),
    .main_y_out     (main_y_out),
    .aux_x_out      (aux_x_out),
    .aux_y_out      (aux_y_out),
    .main_magnitude (main_magnitude),
    .aux_magnitude  (aux_magnitude),
    .press_age      (press_age),
    .held_frames    (held_frames)
  );

endmodule

`default_nettype wire
